// ----- design/pre_pkg.sv -----
// shared types, codes and constants of the palette run-length encoder
package pre_pkg;

  // request codes
  localparam logic [1:0] OP_PIXEL  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // result kinds
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;

  // register indexes, selected by paddr[2]
  localparam logic REG_PALETTE_BITS = 1'b0;
  localparam logic REG_LONG_RUNS    = 1'b1;

  // reset values of the registers
  localparam logic [3:0] PALETTE_BITS_RST = 4'd8;
  localparam logic       LONG_RUNS_RST    = 1'b1;

  // run caps
  localparam logic [15:0] CAP_SMALL_SHORT = 16'd63;
  localparam logic [15:0] CAP_SMALL_LONG  = 16'd16383;
  localparam logic [15:0] CAP_SHORT       = 16'd255;
  localparam logic [15:0] CAP_LONG        = 16'd65535;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
    logic [7:0] entry_index;
  } pre_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  run_index;
    logic [15:0] run_length;
    logic        final_run;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [7:0]  entry_alpha;
    logic [8:0]  color_count;
    logic        overflow;
  } pre_out_t;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_COMMIT = 5'b00100,
    ST_RDREQ  = 5'b01000,
    ST_RDOUT  = 5'b10000
  } pre_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic clear;
    logic srch_init;
    logic srch_step;
    logic commit;
    logic rd_sel;
    logic push_entry;
  } pre_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_done;
    logic space;
  } pre_stat_t;

endpackage

// ----- design/pre_ctrl.sv -----
// controller state machine of the palette run-length encoder
module pre_ctrl import pre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  pre_stat_t  stat,
  output pre_cmd_t   cmd
);

  pre_state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = stat.space;
        if (in_valid && stat.space) begin
          cmd.take = 1'b1;
          case (in_op)
            OP_PIXEL: begin
              cmd.srch_init = 1'b1;
              state_nxt     = ST_SEARCH;
            end
            OP_READ:  state_nxt = ST_RDREQ;
            OP_CLEAR: cmd.clear = 1'b1;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (stat.srch_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_RDREQ: begin
        cmd.rd_sel = 1'b1;
        state_nxt  = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd.push_entry = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/pre_dp.sv -----
// datapath: palette memory, search, run state and result queue
module pre_dp import pre_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pre_in_t    in_data,
  input  pre_cmd_t   cmd,
  output pre_stat_t  stat,
  input  logic [3:0] palette_bits,
  input  logic       long_runs,
  output logic       out_valid,
  input  logic       out_ready,
  output pre_out_t   out_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

  logic [31:0] mem [PALETTE_DEPTH];
  logic [31:0] rdata_r;
  logic [AW-1:0] raddr;

  pre_in_t     item_r;
  logic [8:0]  used_r;
  logic [7:0]  cur_idx_r;
  logic [15:0] cur_len_r;
  logic        ovf_r;
  logic [8:0]  sp_r;
  logic        cmp_v_r;
  logic [7:0]  cmp_idx_r;
  logic        found_r;
  logic [7:0]  fidx_r;

  pre_out_t    q_r [4];
  logic [1:0]  head_r, tail_r;
  logic [2:0]  cnt_r;

  logic [31:0] colour;
  logic        hit, miss;

  // pixel colour, red high
  assign colour = {item_r.red, item_r.green, item_r.blue, item_r.alpha};

  // palette memory read address: entry readout or search pointer
  assign raddr = cmd.rd_sel ? item_r.entry_index[AW-1:0] : sp_r[AW-1:0];

  // compare of the entry read last cycle, both transparent counts as equal
  assign hit  = cmp_v_r && (((colour[7:0] == 8'd0) && (rdata_r[7:0] == 8'd0))
                            || (colour == rdata_r));
  assign miss = !cmp_v_r && (sp_r >= used_r);
  assign stat.srch_done = hit || miss;
  assign stat.space     = (cnt_r <= 3'd2);

  // mode decode
  logic [1:0]  bsel;
  logic [8:0]  capacity;
  logic [15:0] cap;
  always_comb begin
    bsel = (palette_bits < 4'd4) ? 2'd0 : ((palette_bits < 4'd8) ? 2'd1 : 2'd2);
    case (bsel)
      2'd0:    capacity = 9'd4;
      2'd1:    capacity = 9'd16;
      default: capacity = 9'd256;
    endcase
    if (capacity > DEPTH9) capacity = DEPTH9;
    if (bsel == 2'd0) cap = long_runs ? CAP_SMALL_LONG : CAP_SMALL_SHORT;
    else              cap = long_runs ? CAP_LONG : CAP_SHORT;
  end

  // pixel commit: palette update, run update and tokens; palette readout result
  logic        add_new;
  logic [7:0]  idx;
  logic [8:0]  used_nxt;
  logic        ovf_nxt;
  logic [7:0]  ci_nxt, ci_mid;
  logic [15:0] cl_nxt, cl_mid;
  logic        tok_a;
  pre_out_t    tok_a_d, tok_b_d, e0, e1, rd_d;
  logic [1:0]  push_n;
  always_comb begin
    add_new  = !found_r && (used_r < capacity);
    used_nxt = add_new ? used_r + 9'd1 : used_r;
    ovf_nxt  = ovf_r || (!found_r && !add_new);
    if (found_r)      idx = fidx_r;
    else if (add_new) idx = used_r[7:0];
    else              idx = 8'(capacity - 9'd1);
    tok_a  = 1'b0;
    ci_mid = idx;
    cl_mid = 16'd1;
    if (cur_len_r == 16'd0) begin
      ci_mid = idx;
    end else if (idx == cur_idx_r && cur_len_r < cap) begin
      ci_mid = cur_idx_r;
      cl_mid = cur_len_r + 16'd1;
    end else begin
      tok_a = 1'b1;
    end
    ci_nxt = ci_mid;
    cl_nxt = item_r.last_pixel ? 16'd0 : cl_mid;
    tok_a_d = '{kind: KIND_RUN, run_index: cur_idx_r, run_length: cur_len_r,
                final_run: 1'b0, entry_red: 8'd0, entry_green: 8'd0,
                entry_blue: 8'd0, entry_alpha: 8'd0, color_count: used_nxt,
                overflow: ovf_nxt};
    tok_b_d = '{kind: KIND_RUN, run_index: ci_mid, run_length: cl_mid,
                final_run: 1'b1, entry_red: 8'd0, entry_green: 8'd0,
                entry_blue: 8'd0, entry_alpha: 8'd0, color_count: used_nxt,
                overflow: ovf_nxt};
    rd_d = '{kind: KIND_ENTRY, run_index: 8'd0, run_length: 16'd0,
             final_run: 1'b0, entry_red: 8'd0, entry_green: 8'd0,
             entry_blue: 8'd0, entry_alpha: 8'd0, color_count: used_r,
             overflow: ovf_r};
    if ({1'b0, item_r.entry_index} < used_r) begin
      rd_d.entry_red   = rdata_r[31:24];
      rd_d.entry_green = rdata_r[23:16];
      rd_d.entry_blue  = rdata_r[15:8];
      rd_d.entry_alpha = rdata_r[7:0];
    end
    e0 = tok_a ? tok_a_d : tok_b_d;
    e1 = tok_b_d;
    push_n = 2'd0;
    if (cmd.commit)          push_n = {1'b0, tok_a} + {1'b0, item_r.last_pixel};
    else if (cmd.push_entry) push_n = 2'd1;
    if (cmd.push_entry) e0 = rd_d;
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (cmd.commit && add_new) mem[used_r[AW-1:0]] <= colour;
    rdata_r <= mem[raddr];
  end

  // request latch and search result
  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_data;
    if (cmd.srch_step && stat.srch_done) begin
      found_r <= hit;
      fidx_r  <= cmp_idx_r;
    end
    if (cmd.srch_step && !stat.srch_done && sp_r < used_r) cmp_idx_r <= sp_r[7:0];
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= 9'd0;
      cur_idx_r <= 8'd0;
      cur_len_r <= 16'd0;
      ovf_r     <= 1'b0;
      sp_r      <= 9'd0;
      cmp_v_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        used_r    <= 9'd0;
        cur_idx_r <= 8'd0;
        cur_len_r <= 16'd0;
        ovf_r     <= 1'b0;
      end
      if (cmd.srch_init) begin
        sp_r    <= 9'd0;
        cmp_v_r <= 1'b0;
      end else if (cmd.srch_step) begin
        if (!stat.srch_done && sp_r < used_r) begin
          sp_r    <= sp_r + 9'd1;
          cmp_v_r <= 1'b1;
        end else begin
          cmp_v_r <= 1'b0;
        end
      end
      if (cmd.commit) begin
        used_r    <= used_nxt;
        ovf_r     <= ovf_nxt;
        cur_idx_r <= ci_nxt;
        cur_len_r <= cl_nxt;
      end
    end
  end

  // result queue, up to two pushes a cycle
  logic pop;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[head_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[tail_r] <= e0;
    if (push_n == 2'd2) q_r[tail_r + 2'd1] <= e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 2'd0;
      tail_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      tail_r <= tail_r + push_n;
      if (pop) head_r <= head_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_n} - {2'd0, pop};
    end
  end

endmodule

// ----- design/palette_rle_image_encoder_unit.sv -----
// top level: register port, controller and datapath of the palette encoder
// a pixel is searched one entry per cycle through the palette memory read port,
// from entry 0 to a match or past the used entries, then committed; a palette
// read passes ST_RDREQ and ST_RDOUT, a clear stays in idle; one request at a time
// results are queued, four deep; a request is taken while at most two results wait
// reset (synchronous, rst_n low) empties palette, run and queue, no clearing pass
module palette_rle_image_encoder_unit import pre_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pre_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pre_out_t    out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] palette_bits_r;
  logic       long_runs_r;
  pre_cmd_t   cmd;
  pre_stat_t  stat;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_bits_r <= PALETTE_BITS_RST;
      long_runs_r    <= LONG_RUNS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_PALETTE_BITS: palette_bits_r <= pwdata[3:0];
        REG_LONG_RUNS:    long_runs_r    <= pwdata[0];
        default:          long_runs_r    <= long_runs_r;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      REG_PALETTE_BITS: prdata = {28'd0, palette_bits_r};
      REG_LONG_RUNS:    prdata = {31'd0, long_runs_r};
      default:          prdata = 32'd0;
    endcase
  end

  pre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.opcode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pre_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cmd          (cmd),
    .stat         (stat),
    .palette_bits (palette_bits_r),
    .long_runs    (long_runs_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ----- bench/palette_rle_image_encoder_unit_test.sv -----
// testbench of the palette run-length encoder: random images against a built-in predictor
`timescale 1ns / 1ps

module palette_rle_image_encoder_unit_test;
  import pre_pkg::*;

  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pre_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pre_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  palette_rle_image_encoder_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // requests waiting to be offered, and results the encoder owes
  pre_in_t  request_q[$];
  pre_out_t token_q[$];

  // predictor state and register copies
  logic [31:0] pal_store[256];
  logic [8:0]  pal_used;
  logic [7:0]  run_idx;
  int          run_len;
  logic        pal_ovf;
  logic [3:0]  cfg_bits;
  logic        cfg_long;

  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;
  int     errors;
  int     requests_sent;
  int     tokens_seen;
  int     entries_seen;
  longint cycle_count;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // palette search mirror and run merge for one accepted request
  function automatic void push_run(logic [7:0] idx, int len, logic fin);
    pre_out_t o;
    o = '0;
    o.kind        = KIND_RUN;
    o.run_index   = idx;
    o.run_length  = len[15:0];
    o.final_run   = fin;
    o.color_count = pal_used;
    o.overflow    = pal_ovf;
    token_q.push_back(o);
  endfunction

  function automatic void encode_request(pre_in_t r);
    pre_out_t    o;
    logic [31:0] col;
    int          bits;
    int          capacity;
    int          cap;
    int          k;
    logic [7:0]  idx;
    bit          found;
    case (r.opcode)
      OP_CLEAR: begin
        pal_used = '0;
        run_idx  = '0;
        run_len  = 0;
        pal_ovf  = 1'b0;
      end
      OP_READ: begin
        o = '0;
        o.kind = KIND_ENTRY;
        if (r.entry_index < pal_used)
          {o.entry_red, o.entry_green, o.entry_blue, o.entry_alpha} = pal_store[r.entry_index];
        o.color_count = pal_used;
        o.overflow    = pal_ovf;
        token_q.push_back(o);
      end
      OP_PIXEL: begin
        col      = {r.red, r.green, r.blue, r.alpha};
        bits     = cfg_bits < 4 ? 2 : (cfg_bits < 8 ? 4 : 8);
        capacity = 1 << bits;
        if (bits == 2) cap = int'(cfg_long ? CAP_SMALL_LONG : CAP_SMALL_SHORT);
        else           cap = int'(cfg_long ? CAP_LONG : CAP_SHORT);
        found = 1'b0;
        idx   = '0;
        // transparent colours match whatever their rgb
        for (k = 0; k < pal_used && !found; k++) begin
          if ((col[7:0] == 8'd0 && pal_store[k][7:0] == 8'd0) || col == pal_store[k]) begin
            idx   = k[7:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (pal_used < capacity) begin
            pal_store[pal_used[7:0]] = col;
            idx      = pal_used[7:0];
            pal_used = pal_used + 1'b1;
          end else begin
            pal_ovf = 1'b1;
            idx     = 8'(capacity - 1);
          end
        end
        if (run_len == 0) begin
          run_idx = idx;
          run_len = 1;
        end else if (idx == run_idx && run_len < cap) begin
          run_len++;
        end else begin
          push_run(run_idx, run_len, 1'b0);
          run_idx = idx;
          run_len = 1;
        end
        if (r.last_pixel) begin
          push_run(run_idx, run_len, 1'b1);
          run_len = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_request(in_data);
        requests_sent++;
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    pre_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        $error("unexpected result: kind %0d", out_data.kind);
        errors++;
      end else begin
        e = token_q.pop_front();
        check_field("kind", e.kind, out_data.kind);
        check_field("run_index", e.run_index, out_data.run_index);
        check_field("run_length", e.run_length, out_data.run_length);
        check_field("final_run", e.final_run, out_data.final_run);
        check_field("entry_red", e.entry_red, out_data.entry_red);
        check_field("entry_green", e.entry_green, out_data.entry_green);
        check_field("entry_blue", e.entry_blue, out_data.entry_blue);
        check_field("entry_alpha", e.entry_alpha, out_data.entry_alpha);
        check_field("color_count", e.color_count, out_data.color_count);
        check_field("overflow", e.overflow, out_data.overflow);
        if (e.kind == KIND_RUN) tokens_seen++;
        else entries_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic pre_in_t make_req(logic [1:0] op, logic [31:0] rgba, logic last,
                                       logic [7:0] entry);
    pre_in_t r;
    r.opcode      = op;
    {r.red, r.green, r.blue, r.alpha} = rgba;
    r.last_pixel  = last;
    r.entry_index = entry;
    return r;
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  // one image of runs drawn from a small colour pool, with reads and noise mixed in
  task automatic queue_image(int npix, int ncolours, int maxrun);
    logic [31:0] pool[$];
    logic [31:0] col;
    int          i;
    int          n;
    int          len;
    for (i = 0; i < ncolours; i++) begin
      col = $urandom;
      if ($urandom_range(5) == 0) col[7:0] = 8'd0;
      pool.push_back(col);
    end
    n = 0;
    while (n < npix) begin
      col = pool[$urandom_range(ncolours - 1)];
      // a transparent colour may come back with other rgb
      if (col[7:0] == 8'd0) col[31:8] = 24'($urandom);
      len = $urandom_range(1, maxrun);
      for (i = 0; i < len && n < npix; i++) begin
        n++;
        request_q.push_back(make_req(OP_PIXEL, col, n == npix, rnd8()));
        case ($urandom_range(39))
          0, 1: request_q.push_back(make_req(OP_READ, $urandom, 1'($urandom_range(1)),
                  $urandom_range(1) ? rnd8() : 8'($urandom_range(ncolours))));
          2: request_q.push_back(make_req(OP_UNUSED, $urandom, 1'($urandom_range(1)),
                  rnd8()));
          default: ;
        endcase
      end
    end
    if ($urandom_range(19) == 0)
      request_q.push_back(make_req(OP_CLEAR, $urandom, 1'($urandom_range(1)), rnd8()));
  endtask

  // wait until all requests are in and all results out, then let the last pixel settle
  task automatic drain();
    while (request_q.size() > 0 || in_valid || token_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: setup then access; the register takes it at the access edge
  task automatic write_reg(int idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_PALETTE_BITS) cfg_bits = val[3:0];
    else cfg_long = val[0];
  endtask

  initial begin
    int phase;
    int img;
    int i;
    int bits_set[8];
    int long_set[8];
    bits_set = '{2, 4, 8, 0, 15, 5, 3, 8};
    long_set = '{0, 0, 0, 1, 1, 1, 0, 1};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pal_used = '0;
    run_idx = '0;
    run_len = 0;
    pal_ovf = 1'b0;
    cfg_bits = PALETTE_BITS_RST;
    cfg_long = LONG_RUNS_RST;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    errors = 0;
    requests_sent = 0;
    tokens_seen = 0;
    entries_seen = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, colour extremes, transparency, clear and the unused opcode
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd255));
    request_q.push_back(make_req(OP_PIXEL, 32'h00000000, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_PIXEL, 32'hFFFFFF00, 1'b0, 8'hFF));
    request_q.push_back(make_req(OP_PIXEL, 32'hFFFFFFFF, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_PIXEL, 32'hFFFFFFFF, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_UNUSED, 32'hFFFFFFFF, 1'b1, 8'hFF));
    request_q.push_back(make_req(OP_PIXEL, 32'h12345600, 1'b1, 8'd0));
    request_q.push_back(make_req(OP_PIXEL, 32'hFFFFFFFF, 1'b1, 8'd0));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd1));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd2));
    request_q.push_back(make_req(OP_PIXEL, 32'h80808080, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_CLEAR, 32'h0, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd0));
    request_q.push_back(make_req(OP_PIXEL, 32'h01020304, 1'b1, 8'd0));
    drain();

    // small palette overflow
    write_reg(REG_PALETTE_BITS, 32'd2);
    for (i = 0; i < 6; i++)
      request_q.push_back(make_req(OP_PIXEL, 32'h10203040 + i, i == 5, 8'd0));
    request_q.push_back(make_req(OP_READ, 32'h0, 1'b0, 8'd3));
    drain();

    // a run left open, then a tighter cap takes over mid-image
    write_reg(REG_PALETTE_BITS, 32'd8);
    write_reg(REG_LONG_RUNS, 32'd1);
    for (i = 0; i < 70; i++)
      request_q.push_back(make_req(OP_PIXEL, 32'hA5A5A5A5, 1'b0, rnd8()));
    drain();

    for (phase = 0; phase < 8; phase++) begin
      write_reg(REG_PALETTE_BITS, bits_set[phase]);
      write_reg(REG_LONG_RUNS, long_set[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      for (img = 0; img < 5; img++)
        queue_image($urandom_range(8, 30), $urandom_range(1, 20), $urandom_range(1, 12));
      if (phase == 0) queue_image(140, 2, 80);
      if (phase == 2) queue_image(270, 1, 270);
      if (phase == 5) hold_left = 800;
      drain();
    end

    $display("requests accepted: %0d, run tokens checked: %0d, palette reads checked: %0d",
             requests_sent, tokens_seen, entries_seen);
    $display("covered palette sizes 4/16/256, short and long caps, overflow and idle mixes");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/pre_pkg.sv
design/pre_ctrl.sv
design/pre_dp.sv
design/palette_rle_image_encoder_unit.sv
bench/palette_rle_image_encoder_unit_test.sv
